[rtl/terminal_display_word_decoder_assert.svh]
// Assertion macros for the terminal display word decoder.
// Used by the back end; expects clk and rst_n in scope.
`ifndef TERMINAL_DISPLAY_WORD_DECODER_ASSERT_SVH
`define TERMINAL_DISPLAY_WORD_DECODER_ASSERT_SVH

// Same-cycle implication.
`define TDWD_ASSERT_NOW(label, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// Next-cycle implication.
`define TDWD_ASSERT_NEXT(label, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

[rtl/tdwd_pkg.sv]
// Shared types and constants of the terminal display word decoder.
// No dependencies.
package tdwd_pkg;

    localparam int GLYPH_WORDS = 1024;
    localparam int GA_W        = 10;

    typedef enum logic [3:0] {
        EV_DOT     = 4'd0,
        EV_LINE    = 4'd1,
        EV_CHAR    = 4'd2,
        EV_GLYPH   = 4'd3,
        EV_ECHO    = 4'd4,
        EV_ERASE   = 4'd5,
        EV_WMODE   = 4'd6,
        EV_TOUCH   = 4'd7,
        EV_STATION = 4'd8
    } ev_kind_t;

    typedef enum logic [2:0] {
        CL_DATA    = 3'd0,
        CL_STATION = 3'd1,
        CL_MODE    = 3'd2,
        CL_COORD   = 3'd3,
        CL_ECHO    = 3'd4,
        CL_ADDR    = 3'd5
    } cls_t;

    localparam logic [2:0] CMD_NOP   = 3'd0;
    localparam logic [2:0] CMD_MODE  = 3'd1;
    localparam logic [2:0] CMD_COORD = 3'd2;
    localparam logic [2:0] CMD_ECHO  = 3'd3;
    localparam logic [2:0] CMD_ADDR  = 3'd4;

    localparam logic [1:0] DM_DOT  = 2'd0;
    localparam logic [1:0] DM_LINE = 2'd1;
    localparam logic [1:0] DM_LOAD = 2'd2;
    localparam logic [1:0] DM_TEXT = 2'd3;

    localparam logic [5:0] CH_ESC     = 6'o77;
    localparam logic [5:0] CH_BS      = 6'o10;
    localparam logic [5:0] CH_FWD     = 6'o11;
    localparam logic [5:0] CH_DOWN    = 6'o12;
    localparam logic [5:0] CH_UP      = 6'o13;
    localparam logic [5:0] CH_HOME    = 6'o14;
    localparam logic [5:0] CH_CR      = 6'o15;
    localparam logic [5:0] CH_SUPER   = 6'o16;
    localparam logic [5:0] CH_SUB     = 6'o17;
    localparam logic [5:0] CH_SET0    = 6'o20;
    localparam logic [5:0] CH_SET1    = 6'o21;
    localparam logic [5:0] CH_SET2    = 6'o22;
    localparam logic [5:0] CH_SET3    = 6'o23;

    localparam logic [5:0] NOP_STATION = 6'o42;
    localparam logic [6:0] KEY_TYPE    = 7'o160;
    localparam logic [15:0] TYPE_BASE  = 16'o360;
    localparam logic [15:0] KEY_BASE   = 16'o200;
    localparam logic [8:0] HOME_Y      = 9'd496;
    localparam logic [GA_W-1:0] GLYPH_LIMIT = 10'd1016;

    typedef struct packed {
        cls_t        cls;
        logic [18:0] word;
    } qent_t;

    typedef struct packed {
        ev_kind_t    kind;
        logic [8:0]  from_x;
        logic [8:0]  from_y;
        logic [8:0]  to_x;
        logic [8:0]  to_y;
        logic [1:0]  char_set;
        logic [5:0]  char_code;
        logic [2:0]  glyph_row;
        logic [15:0] value;
        logic        last;
    } evt_t;

endpackage

[rtl/tdwd_if.sv]
// Handshake channels of the terminal display word decoder.
// No dependencies.
interface tdwd_word_if;
    logic        valid;
    logic        ready;
    logic [9:0]  station;
    logic [18:0] word;
    modport source (output valid, station, word, input ready);
    modport sink   (input valid, station, word, output ready);
endinterface

interface tdwd_evt_if;
    logic        valid;
    logic        ready;
    logic [3:0]  event_kind;
    logic [8:0]  from_x;
    logic [8:0]  from_y;
    logic [8:0]  to_x;
    logic [8:0]  to_y;
    logic [1:0]  char_set;
    logic [5:0]  char_code;
    logic [2:0]  glyph_row;
    logic [15:0] value;
    logic        last;
    modport source (output valid, event_kind, from_x, from_y, to_x, to_y, char_set,
                    char_code, glyph_row, value, last, input ready);
    modport sink   (input valid, event_kind, from_x, from_y, to_x, to_y, char_set,
                    char_code, glyph_row, value, last, output ready);
endinterface

[rtl/terminal_display_word_decoder.sv]
// Top level of the terminal display word decoder.
// Depends on tdwd_pkg, tdwd_if, tdwd_front, tdwd_queue and tdwd_back.
//
// Words for station 1 are queued and carried out one at a time by the back end.
// A mode load emits an optional erase, a write-mode and a touch event, a text
// word up to three characters; a completed glyph sends its eight stored words,
// one per row, each read first through the single read port of the glyph memory.
// Output waits stall; a two-entry queue keeps the input side taking words.
module terminal_display_word_decoder
    import tdwd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [8:0]  cfg_data,
    tdwd_word_if.sink   words_in,
    tdwd_evt_if.source  events_out
);
    logic  q_push, q_full, q_pop, q_avail;
    qent_t q_in, q_out;

    tdwd_front u_front (
        .words_in (words_in),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    tdwd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .avail     (q_avail),
        .pop_data  (q_out)
    );

    tdwd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_avail    (q_avail),
        .q_data     (q_out),
        .q_pop      (q_pop),
        .events_out (events_out)
    );
endmodule

[rtl/tdwd_front.sv]
// Front end: accepts words, drops foreign stations and idle commands, classifies.
// Depends on tdwd_pkg and tdwd_if.
module tdwd_front
    import tdwd_pkg::*;
(
    tdwd_word_if.sink words_in,
    input  logic      q_full,
    output logic      q_push,
    output qent_t     q_data
);
    logic       take;
    logic       keep;
    logic [2:0] cmd;

    assign words_in.ready = !q_full;
    assign take = words_in.valid && !q_full;
    assign cmd  = words_in.word[17:15];

    always_comb
    begin
        keep = 1'b1;
        q_data.word = words_in.word;
        q_data.cls  = CL_DATA;
        if (!words_in.word[18])
        begin
            unique case (cmd)
                CMD_NOP:
                begin
                    q_data.cls = CL_STATION;
                    keep = (words_in.word[14:9] == NOP_STATION);
                end
                CMD_MODE:  q_data.cls = CL_MODE;
                CMD_COORD: q_data.cls = CL_COORD;
                CMD_ECHO:  q_data.cls = CL_ECHO;
                CMD_ADDR:  q_data.cls = CL_ADDR;
                default:   keep = 1'b0;
            endcase
        end
    end

    assign q_push = take && keep && (words_in.station == 10'd1);
endmodule

[rtl/tdwd_queue.sv]
// Two-entry queue between the front and back ends.
// Depends on tdwd_pkg.
module tdwd_queue
    import tdwd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  qent_t push_data,
    output logic  full,
    input  logic  pop,
    output logic  avail,
    output qent_t pop_data
);
    qent_t      ent_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;

    assign full     = (cnt_reg == 2'd2);
    assign avail    = (cnt_reg != 2'd0);
    assign pop_data = ent_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wp_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= !wp_reg;
            end
            if (pop)
            begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

[rtl/tdwd_back.sv]
// Back end: holds terminal state and glyph memory, executes items, emits events.
// Depends on tdwd_pkg, tdwd_if and the assertion header.
`include "terminal_display_word_decoder_assert.svh"
module tdwd_back
    import tdwd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [8:0]  cfg_data,
    input  logic        q_avail,
    input  qent_t       q_data,
    output logic        q_pop,
    tdwd_evt_if.source  events_out
);
    typedef enum logic [1:0] { B_IDLE, B_RUN, B_RD, B_GEMIT } bst_t;

    bst_t           st_reg, st_next;
    qent_t          cur_reg, cur_next;
    logic [1:0]     step_reg, step_next;
    logic [8:0]     cx_reg, cx_next, cy_reg, cy_next;
    logic [1:0]     dm_reg, dm_next, wm_reg, wm_next;
    logic [GA_W-1:0] ga_reg, ga_next;
    logic [1:0]     cs_reg, cs_next;
    logic           esc_reg, esc_next;
    logic [6:0]     gch_reg, gch_next;
    logic [2:0]     row_reg, row_next;
    logic [8:0]     lm_reg;
    logic [3:0]     tt_reg;
    logic           ovld_reg, ovld_next;
    evt_t           oev_reg, oev_next;

    logic [15:0]    mem [GLYPH_WORDS];
    logic [15:0]    rdata_reg;
    logic           mem_we;
    logic [GA_W-1:0] mem_raddr;

    logic           can_emit;
    logic           emit;
    evt_t           ev;
    logic [18:0]    w;
    logic [5:0]     c0, c1, c2, c;
    logic           e1, e2, clast;
    logic [1:0]     wm_new;
    logic [GA_W-1:0] ga_inc;

    assign w        = cur_reg.word;
    assign can_emit = !ovld_reg || events_out.ready;
    assign c0 = w[17:12];
    assign c1 = w[11:6];
    assign c2 = w[5:0];
    assign e1 = (c1 != CH_ESC) && (c0 != CH_ESC);
    assign e2 = (c2 != CH_ESC) && (c1 != CH_ESC);
    assign wm_new = (w[2:1] == 2'd0) ? 2'd2 : w[2:1];
    assign ga_inc = ga_reg + 10'd1;
    assign mem_raddr = {gch_reg, row_reg};

    always_comb
    begin
        c = c2;
        clast = 1'b1;
        unique case (step_reg)
            2'd0:
            begin
                c = c0;
                clast = !(e1 || e2);
            end
            2'd1:
            begin
                c = c1;
                clast = !e2;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        st_next = st_reg;
        cur_next = cur_reg;
        step_next = step_reg;
        cx_next = cx_reg;
        cy_next = cy_reg;
        dm_next = dm_reg;
        wm_next = wm_reg;
        ga_next = ga_reg;
        cs_next = cs_reg;
        esc_next = esc_reg;
        gch_next = gch_reg;
        row_next = row_reg;
        q_pop = 1'b0;
        mem_we = 1'b0;
        emit = 1'b0;
        ev = '0;
        unique case (st_reg)
            B_IDLE:
            begin
                if (q_avail)
                begin
                    q_pop = 1'b1;
                    cur_next = q_data;
                    step_next = 2'd0;
                    st_next = B_RUN;
                end
            end
            B_RUN:
            begin
                unique case (cur_reg.cls)
                    CL_COORD:
                    begin
                        if (w[9])
                        begin
                            cy_next = w[8:0];
                        end
                        else
                        begin
                            cx_next = w[8:0];
                        end
                        st_next = B_IDLE;
                    end
                    CL_ADDR:
                    begin
                        ga_next = w[9:0];
                        st_next = B_IDLE;
                    end
                    CL_STATION:
                    begin
                        if (can_emit)
                        begin
                            emit = 1'b1;
                            ev.kind = EV_STATION;
                            ev.value = {7'd0, w[8:0]};
                            ev.last = 1'b1;
                            st_next = B_IDLE;
                        end
                    end
                    CL_ECHO:
                    begin
                        if (can_emit)
                        begin
                            emit = 1'b1;
                            ev.kind = EV_ECHO;
                            ev.value = (w[6:0] == KEY_TYPE) ? TYPE_BASE + {12'd0, tt_reg}
                                                            : KEY_BASE + {9'd0, w[6:0]};
                            ev.last = 1'b1;
                            st_next = B_IDLE;
                        end
                    end
                    CL_MODE:
                    begin
                        if (can_emit)
                        begin
                            unique case (step_reg)
                                2'd0:
                                begin
                                    dm_next = w[4:3];
                                    wm_next = wm_new;
                                    emit = w[0];
                                    ev.kind = EV_ERASE;
                                    step_next = 2'd1;
                                end
                                2'd1:
                                begin
                                    emit = 1'b1;
                                    ev.kind = EV_WMODE;
                                    ev.value = {14'd0, wm_reg};
                                    step_next = 2'd2;
                                end
                                default:
                                begin
                                    emit = 1'b1;
                                    ev.kind = EV_TOUCH;
                                    ev.value = {15'd0, !w[14]};
                                    ev.last = 1'b1;
                                    st_next = B_IDLE;
                                end
                            endcase
                        end
                    end
                    default:
                    begin
                        unique case (dm_reg)
                            DM_DOT, DM_LINE:
                            begin
                                if (can_emit)
                                begin
                                    emit = 1'b1;
                                    ev.last = 1'b1;
                                    if (dm_reg == DM_DOT)
                                    begin
                                        ev.kind = EV_DOT;
                                        ev.from_x = w[17:9];
                                        ev.from_y = w[8:0];
                                    end
                                    else
                                    begin
                                        ev.kind = EV_LINE;
                                        ev.from_x = cx_reg;
                                        ev.from_y = cy_reg;
                                        ev.to_x = w[17:9];
                                        ev.to_y = w[8:0];
                                    end
                                    cx_next = w[17:9];
                                    cy_next = w[8:0];
                                    st_next = B_IDLE;
                                end
                            end
                            DM_LOAD:
                            begin
                                st_next = B_IDLE;
                                if (ga_reg < GLYPH_LIMIT && w[17:16] == 2'd0)
                                begin
                                    mem_we = 1'b1;
                                    ga_next = ga_inc;
                                    if (ga_inc[2:0] == 3'd0)
                                    begin
                                        gch_next = ga_reg[9:3];
                                        row_next = 3'd0;
                                        st_next = B_RD;
                                    end
                                end
                            end
                            default:
                            begin
                                if (c == CH_ESC)
                                begin
                                    esc_next = 1'b1;
                                end
                                else if (esc_reg)
                                begin
                                    esc_next = 1'b0;
                                    case (c)
                                        CH_BS:    cx_next = cx_reg - 9'd8;
                                        CH_FWD:   cx_next = cx_reg + 9'd8;
                                        CH_DOWN:  cy_next = cy_reg - 9'd16;
                                        CH_UP:    cy_next = cy_reg + 9'd16;
                                        CH_HOME:
                                        begin
                                            cx_next = 9'd0;
                                            cy_next = HOME_Y;
                                        end
                                        CH_CR:
                                        begin
                                            cx_next = lm_reg;
                                            cy_next = cy_reg - 9'd16;
                                        end
                                        CH_SUPER: cy_next = cy_reg + 9'd5;
                                        CH_SUB:   cy_next = cy_reg - 9'd5;
                                        CH_SET0, CH_SET1, CH_SET2, CH_SET3:
                                            cs_next = c[1:0];
                                        default: ;
                                    endcase
                                end
                                else
                                begin
                                    emit = 1'b1;
                                    ev.kind = EV_CHAR;
                                    ev.from_x = cx_reg;
                                    ev.from_y = cy_reg;
                                    ev.char_set = cs_reg;
                                    ev.char_code = c;
                                    ev.last = clast;
                                    cx_next = cx_reg + 9'd8;
                                end
                                if (emit && !can_emit)
                                begin
                                    emit = 1'b0;
                                    esc_next = esc_reg;
                                    cx_next = cx_reg;
                                end
                                else
                                begin
                                    step_next = step_reg + 2'd1;
                                    if (step_reg == 2'd2)
                                    begin
                                        st_next = B_IDLE;
                                    end
                                end
                            end
                        endcase
                    end
                endcase
            end
            B_RD:
            begin
                st_next = B_GEMIT;
            end
            default:
            begin
                if (can_emit)
                begin
                    emit = 1'b1;
                    ev.kind = EV_GLYPH;
                    ev.char_set = {1'b1, gch_reg[6]};
                    ev.char_code = gch_reg[5:0];
                    ev.glyph_row = row_reg;
                    ev.value = rdata_reg;
                    ev.last = (row_reg == 3'd7);
                    row_next = row_reg + 3'd1;
                    st_next = (row_reg == 3'd7) ? B_IDLE : B_RD;
                end
            end
        endcase
    end

    always_comb
    begin
        ovld_next = ovld_reg;
        oev_next = oev_reg;
        if (events_out.ready)
        begin
            ovld_next = 1'b0;
        end
        if (emit)
        begin
            ovld_next = 1'b1;
            oev_next = ev;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[ga_reg] <= w[15:0];
        end
        rdata_reg <= mem[mem_raddr];
        cur_reg <= cur_next;
        oev_reg <= oev_next;
        gch_reg <= gch_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= B_IDLE;
            step_reg <= 2'd0;
            cx_reg   <= 9'd0;
            cy_reg   <= 9'd0;
            dm_reg   <= 2'd0;
            wm_reg   <= 2'd0;
            ga_reg   <= '0;
            cs_reg   <= 2'd0;
            esc_reg  <= 1'b0;
            row_reg  <= 3'd0;
            lm_reg   <= 9'd0;
            tt_reg   <= 4'd0;
            ovld_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            step_reg <= step_next;
            cx_reg   <= cx_next;
            cy_reg   <= cy_next;
            dm_reg   <= dm_next;
            wm_reg   <= wm_next;
            ga_reg   <= ga_next;
            cs_reg   <= cs_next;
            esc_reg  <= esc_next;
            row_reg  <= row_next;
            ovld_reg <= ovld_next;
            if (cfg_we)
            begin
                if (cfg_index)
                begin
                    tt_reg <= cfg_data[3:0];
                end
                else
                begin
                    lm_reg <= cfg_data;
                end
            end
        end
    end

    assign events_out.valid      = ovld_reg;
    assign events_out.event_kind = oev_reg.kind;
    assign events_out.from_x     = oev_reg.from_x;
    assign events_out.from_y     = oev_reg.from_y;
    assign events_out.to_x       = oev_reg.to_x;
    assign events_out.to_y       = oev_reg.to_y;
    assign events_out.char_set   = oev_reg.char_set;
    assign events_out.char_code  = oev_reg.char_code;
    assign events_out.glyph_row  = oev_reg.glyph_row;
    assign events_out.value      = oev_reg.value;
    assign events_out.last       = oev_reg.last;

    `TDWD_ASSERT_NOW(a_pop_idle, q_pop, st_reg == B_IDLE, "queue pop outside idle")
    `TDWD_ASSERT_NOW(a_we_run, mem_we, st_reg == B_RUN && dm_reg == DM_LOAD, "stray glyph write")
    `TDWD_ASSERT_NEXT(a_rd_emit, st_reg == B_RD, st_reg == B_GEMIT, "glyph read not followed")
    `TDWD_ASSERT_NOW(a_emit_slot, emit, can_emit, "event emitted into full slot")
endmodule
